// ===== design/cltok_pkg.sv =====
// Package for the command line tokenizer: sizes, character codes and the
// structs that pass between the front end, the queue and the back end.
// Depends on nothing; every design file refers to it by scoped names.
package cltok_pkg;

  localparam int MaxLine   = 1024;
  localparam int MaxTokens = 64;
  localparam int QDepth    = 2;

  localparam int LinePosW = (MaxLine > 2) ? $clog2(MaxLine) : 1;
  localparam int CountW   = $clog2(MaxTokens + 1);
  localparam int QPtrW    = (QDepth > 2) ? $clog2(QDepth) : 1;
  localparam int QCntW    = $clog2(QDepth + 1);
  localparam int TokIdxW  = 6;
  localparam int ArgCntW  = 7;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHigh  = 8'h80;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       space;
    logic       quote;
    logic       feed;
    logic       drop;
    logic       cmd_end;
  } item_t;

  typedef struct packed {
    logic [7:0]         token_byte;
    logic               token_byte_valid;
    logic [TokIdxW-1:0] token_index;
    logic               token_done;
    logic               args_byte_valid;
    logic               byte_dropped;
    logic               command_end;
    logic [ArgCntW-1:0] arg_count;
  } result_t;

endpackage

// ===== design/command_line_split_tokenize_unit.sv =====
// Top level of the command line tokenizer: front end, item queue, back end.
// Depends on cltok_pkg, cltok_front, cltok_queue and cltok_back.
//
//   Channel  Handshake          Payload
//   input    push / full        byte_value_i, last_byte_i
//   result   empty / pop        token_byte_o ... arg_count_o, one per input byte
//   config   cfg_we_i           cfg_wdata_i (high bytes count as space)
//
// Each byte yields one result; the back end updates its token state once per
// item, and one byte per cycle is sustained while the result consumer pops. The
// result of a transfer passes through the item queue and then the back end's
// result register. A stalled result consumer fills the two-entry item queue
// before full rises. Reset clears all line state and sets high bytes to space.
module command_line_split_tokenize_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       byte_value_i,
  input  logic                             last_byte_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       token_byte_o,
  output logic                             token_byte_valid_o,
  output logic [cltok_pkg::TokIdxW-1:0]    token_index_o,
  output logic                             token_done_o,
  output logic                             args_byte_valid_o,
  output logic                             byte_dropped_o,
  output logic                             command_end_o,
  output logic [cltok_pkg::ArgCntW-1:0]    arg_count_o
);

  cltok_pkg::item_t   fe_item, q_item;
  cltok_pkg::result_t res;
  logic               fe_valid, q_empty, q_pop, res_valid;

  cltok_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_value_i (byte_value_i),
    .last_byte_i  (last_byte_i),
    .push_i       (push),
    .q_full_i     (full),
    .item_valid_o (fe_valid),
    .item_o       (fe_item)
  );

  cltok_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .item_i  (fe_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .empty_o (q_empty)
  );

  cltok_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (~q_empty),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  assign empty              = ~res_valid;
  assign token_byte_o       = res.token_byte;
  assign token_byte_valid_o = res.token_byte_valid;
  assign token_index_o      = res.token_index;
  assign token_done_o       = res.token_done;
  assign args_byte_valid_o  = res.args_byte_valid;
  assign byte_dropped_o     = res.byte_dropped;
  assign command_end_o      = res.command_end;
  assign arg_count_o        = res.arg_count;

endmodule

// ===== design/cltok_front.sv =====
// Front end: takes input bytes, tracks line position and quote parity, and
// classifies each byte into a queue item. Holds the configuration register.
// Depends on cltok_pkg.
module cltok_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic [7:0]         byte_value_i,
  input  logic               last_byte_i,
  input  logic               push_i,
  input  logic               q_full_i,
  output logic               item_valid_o,
  output cltok_pkg::item_t   item_o
);

  logic                          high_space_q;
  logic                          parity_q, parity_d;
  logic [cltok_pkg::LinePosW-1:0] pos_q, pos_d;
  logic                          take;
  logic                          is_quote, is_term, at_limit;

  assign take = push_i & ~q_full_i;
  assign is_quote = (byte_value_i == cltok_pkg::ChQuote);
  assign at_limit = (pos_q == cltok_pkg::LinePosW'(cltok_pkg::MaxLine - 1));

  always_comb begin
    parity_d = parity_q ^ is_quote;
    is_term  = (byte_value_i == cltok_pkg::ChLf) || (byte_value_i == cltok_pkg::ChCr) ||
               ((byte_value_i == cltok_pkg::ChSemi) && !parity_d);
    pos_d    = pos_q + cltok_pkg::LinePosW'(1);

    item_o.byte_value = byte_value_i;
    item_o.quote      = is_quote;
    item_o.space      = (byte_value_i <= cltok_pkg::ChSpace) ||
                        ((byte_value_i >= cltok_pkg::ChHigh) && high_space_q);
    item_o.drop       = at_limit;
    item_o.feed       = !at_limit && !is_term;
    item_o.cmd_end    = at_limit || is_term || last_byte_i;

    if (item_o.cmd_end) begin
      pos_d    = '0;
      parity_d = 1'b0;
    end
  end

  assign item_valid_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_space_q <= 1'b1;
      parity_q     <= 1'b0;
      pos_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        high_space_q <= cfg_wdata_i;
      end
      if (take) begin
        parity_q <= parity_d;
        pos_q    <= pos_d;
      end
    end
  end

endmodule

// ===== design/cltok_queue.sv =====
// Short queue of classified items between the front end and the back end.
// Depends on cltok_pkg for the item type and the depth.
module cltok_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cltok_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output cltok_pkg::item_t item_o,
  output logic             empty_o
);

  cltok_pkg::item_t                 mem_q [cltok_pkg::QDepth];
  logic [cltok_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [cltok_pkg::QCntW-1:0]      cnt_q;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == cltok_pkg::QCntW'(cltok_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == cltok_pkg::QPtrW'(cltok_pkg::QDepth - 1)) ? '0 :
                wr_q + cltok_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == cltok_pkg::QPtrW'(cltok_pkg::QDepth - 1)) ? '0 :
                rd_q + cltok_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + cltok_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - cltok_pkg::QCntW'(1);
      end
    end
  end

endmodule

// ===== design/cltok_back.sv =====
// Back end: runs the token state machine on queued items and holds the
// result register that the consumer pops. Depends on cltok_pkg.
module cltok_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  cltok_pkg::item_t   item_i,
  output logic               item_pop_o,
  output logic               res_valid_o,
  output cltok_pkg::result_t res_o,
  input  logic               res_pop_i
);

  typedef enum logic [1:0] {
    ModeBetween,
    ModePlain,
    ModeQuoted,
    ModeIgnore
  } mode_e;

  mode_e                          mode_q, mode_d;
  logic [cltok_pkg::CountW-1:0]   count_q, count_d;
  logic                           args_q, args_d;
  logic                           valid_q;
  cltok_pkg::result_t             res_q, res_d;
  logic                           step;

  assign step        = item_valid_i & (~valid_q | res_pop_i);
  assign item_pop_o  = step;
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    res_d   = '0;
    mode_d  = mode_q;
    count_d = count_q;
    args_d  = args_q;

    if (item_i.feed) begin
      case (mode_q)
        ModeBetween: begin
          if (!item_i.space) begin
            if (count_q == cltok_pkg::CountW'(1)) begin
              args_d = 1'b1;
            end
            if (count_q >= cltok_pkg::CountW'(cltok_pkg::MaxTokens)) begin
              mode_d = ModeIgnore;
            end else begin
              res_d.token_index = cltok_pkg::TokIdxW'(count_q);
              count_d = count_q + cltok_pkg::CountW'(1);
              if (item_i.quote) begin
                mode_d = ModeQuoted;
              end else begin
                mode_d = ModePlain;
                res_d.token_byte       = item_i.byte_value;
                res_d.token_byte_valid = 1'b1;
              end
            end
          end
        end
        ModePlain: begin
          res_d.token_index = cltok_pkg::TokIdxW'(count_q - cltok_pkg::CountW'(1));
          if (item_i.space) begin
            res_d.token_done = 1'b1;
            mode_d = ModeBetween;
          end else begin
            res_d.token_byte       = item_i.byte_value;
            res_d.token_byte_valid = 1'b1;
          end
        end
        ModeQuoted: begin
          res_d.token_index = cltok_pkg::TokIdxW'(count_q - cltok_pkg::CountW'(1));
          if (item_i.quote) begin
            res_d.token_done = 1'b1;
            mode_d = ModeBetween;
          end else begin
            res_d.token_byte       = item_i.byte_value;
            res_d.token_byte_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res_d.args_byte_valid = args_d;
    end

    res_d.byte_dropped = item_i.drop;

    if (item_i.cmd_end) begin
      if (mode_d == ModePlain || mode_d == ModeQuoted) begin
        res_d.token_done  = 1'b1;
        res_d.token_index = cltok_pkg::TokIdxW'(count_d - cltok_pkg::CountW'(1));
      end
      res_d.command_end = 1'b1;
      res_d.arg_count   = cltok_pkg::ArgCntW'(count_d);
      mode_d  = ModeBetween;
      count_d = '0;
      args_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeBetween;
      count_q <= '0;
      args_q  <= 1'b0;
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      if (step) begin
        mode_q  <= mode_d;
        count_q <= count_d;
        args_q  <= args_d;
        res_q   <= res_d;
        valid_q <= 1'b1;
      end else if (res_pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule
